[hdl/sefr_pkg.sv]
// shared types, constants and crc function for the framed byte receiver
package sefr_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 17;
    localparam int ERR_W   = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic [LEN_W-1:0] CRC_POLY = 16'h8005;

    typedef logic [ERR_W-1:0] frame_err_t;

    localparam frame_err_t ERR_NONE   = 2'd0;
    localparam frame_err_t ERR_CRC    = 2'd1;
    localparam frame_err_t ERR_END    = 2'd2;
    localparam frame_err_t ERR_LENGTH = 2'd3;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_START_MARKER = 2'd0;
    localparam reg_idx_t REG_END_MARKER   = 2'd1;
    localparam reg_idx_t REG_MAX_LENGTH   = 2'd2;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 16'd1024;

    typedef struct packed {
        logic                 msg_valid;
        logic [BYTE_W-1:0]    msg_byte;
        logic [IDX_W-1:0]     msg_index;
        logic                 frame_ok;
        logic [IDX_W-1:0]     frame_length;
        frame_err_t           frame_error;
        logic [BYTE_W-1:0]    seq_number;
    } result_t;

    // crc-16 over one byte, msb first, no reflection
    function automatic logic [LEN_W-1:0] crc_byte(
        input logic [LEN_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [LEN_W-1:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (crc[LEN_W-1])
            begin
                crc = {crc[LEN_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[LEN_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

[hdl/stx_etx_frame_receiver_crc16.sv]
// framed byte receiver with crc-16 check, top level
// Takes one received byte per transfer and returns one result per byte. Each
// byte is captured in an input register, parsed against the frame state by a
// single layer of logic (including the unrolled crc-16 byte update) and stored
// in a result register, so the block sustains one byte per clock cycle while
// out_stall does not hold the result register. The instruction, length and
// data bytes are streamed out with their message index; the end of a good
// frame reports its message length and the advanced link sequence number,
// while crc mismatch, bad end marker or an oversize length return the parser
// to idle with an error code. abort returns the parser to idle at once. The
// user must set markers, length limit by register port while idle (unchecked).
module stx_etx_frame_receiver_crc16
    import sefr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     rx_byte,
    input  logic                  abort,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  msg_valid,
    output logic [BYTE_W-1:0]     msg_byte,
    output logic [IDX_W-1:0]      msg_index,
    output logic                  frame_ok,
    output logic [IDX_W-1:0]      frame_length,
    output logic [ERR_W-1:0]      frame_error,
    output logic [BYTE_W-1:0]     seq_number
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SEQ   = 4'd1;
    localparam logic [3:0] ST_TXI_H = 4'd2;
    localparam logic [3:0] ST_TXI_L = 4'd3;
    localparam logic [3:0] ST_RXI_H = 4'd4;
    localparam logic [3:0] ST_RXI_L = 4'd5;
    localparam logic [3:0] ST_INST  = 4'd6;
    localparam logic [3:0] ST_LEN_H = 4'd7;
    localparam logic [3:0] ST_LEN_L = 4'd8;
    localparam logic [3:0] ST_DATA  = 4'd9;
    localparam logic [3:0] ST_CRC_H = 4'd10;
    localparam logic [3:0] ST_CRC_L = 4'd11;
    localparam logic [3:0] ST_END   = 4'd12;

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    logic [LEN_W-1:0]  max_length_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_abort_reg;

    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;
    logic [LEN_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] link_seq_reg, link_seq_next;

    logic              out_free;
    logic              s1_fire;
    logic              in_fire;
    logic              cfg_write;
    reg_idx_t          cfg_idx;
    logic [LEN_W-1:0]  crc_upd;
    logic [LEN_W-1:0]  len_full;
    logic [LEN_W-1:0]  rem_dec;
    logic [BYTE_W-1:0] seq_inc;

    // register port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_START_MARKER: prdata = {{(APB_DW-BYTE_W){1'b0}}, start_marker_reg};
            REG_END_MARKER:   prdata = {{(APB_DW-BYTE_W){1'b0}}, end_marker_reg};
            REG_MAX_LENGTH:   prdata = {{(APB_DW-LEN_W){1'b0}}, max_length_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
            max_length_reg   <= MAX_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_START_MARKER: start_marker_reg <= pwdata[BYTE_W-1:0];
                REG_END_MARKER:   end_marker_reg   <= pwdata[BYTE_W-1:0];
                REG_MAX_LENGTH:   max_length_reg   <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= rx_byte;
            s1_abort_reg <= abort;
        end
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    // frame parser
    assign crc_upd  = crc_byte(crc_reg, s1_byte_reg);
    assign len_full = {remaining_reg[LEN_W-1:BYTE_W], s1_byte_reg};
    assign rem_dec  = remaining_reg - 1'b1;
    assign seq_inc  = (link_seq_reg == {BYTE_W{1'b1}}) ? 8'd1 : link_seq_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        byte_index_next = byte_index_reg;
        remaining_next  = remaining_reg;
        crc_next        = crc_reg;
        link_seq_next   = link_seq_reg;
        res_next        = '0;

        if (s1_abort_reg)
        begin
            state_next      = ST_IDLE;
            byte_index_next = '0;
            remaining_next  = '0;
            crc_next        = '0;
        end
        else
        begin
            case (state_reg)
                ST_SEQ:
                begin
                    crc_next   = crc_byte('0, s1_byte_reg);
                    state_next = ST_TXI_H;
                end
                ST_TXI_H, ST_TXI_L, ST_RXI_H, ST_RXI_L:
                begin
                    crc_next   = crc_upd;
                    state_next = state_reg + 1'b1;
                end
                ST_INST, ST_LEN_H, ST_LEN_L, ST_DATA:
                begin
                    crc_next           = crc_upd;
                    res_next.msg_valid = 1'b1;
                    res_next.msg_byte  = s1_byte_reg;
                    res_next.msg_index = byte_index_reg;
                    byte_index_next    = byte_index_reg + 1'b1;
                    if (state_reg == ST_INST)
                    begin
                        state_next = ST_LEN_H;
                    end
                    else if (state_reg == ST_LEN_H)
                    begin
                        remaining_next = {s1_byte_reg, 8'h00};
                        state_next     = ST_LEN_L;
                    end
                    else if (state_reg == ST_LEN_L)
                    begin
                        if (len_full > max_length_reg)
                        begin
                            res_next.frame_error = ERR_LENGTH;
                            state_next           = ST_IDLE;
                            byte_index_next      = '0;
                            remaining_next       = '0;
                            crc_next             = '0;
                        end
                        else
                        begin
                            remaining_next = len_full;
                            state_next     = (len_full != '0) ? ST_DATA : ST_CRC_H;
                        end
                    end
                    else
                    begin
                        remaining_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            state_next = ST_CRC_H;
                        end
                    end
                end
                ST_CRC_H:
                begin
                    if (s1_byte_reg == crc_reg[LEN_W-1:BYTE_W])
                    begin
                        state_next = ST_CRC_L;
                    end
                    else
                    begin
                        res_next.frame_error = ERR_CRC;
                        state_next           = ST_IDLE;
                        byte_index_next      = '0;
                        remaining_next       = '0;
                        crc_next             = '0;
                    end
                end
                ST_CRC_L:
                begin
                    if (s1_byte_reg == crc_reg[BYTE_W-1:0])
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        res_next.frame_error = ERR_CRC;
                        state_next           = ST_IDLE;
                        byte_index_next      = '0;
                        remaining_next       = '0;
                        crc_next             = '0;
                    end
                end
                ST_END:
                begin
                    if (s1_byte_reg == end_marker_reg)
                    begin
                        link_seq_next         = seq_inc;
                        res_next.frame_ok     = 1'b1;
                        res_next.frame_length = byte_index_reg;
                    end
                    else
                    begin
                        res_next.frame_error = ERR_END;
                    end
                    state_next      = ST_IDLE;
                    byte_index_next = '0;
                    remaining_next  = '0;
                    crc_next        = '0;
                end
                default:
                begin
                    byte_index_next = '0;
                    remaining_next  = '0;
                    crc_next        = '0;
                    state_next      = (s1_byte_reg == start_marker_reg) ? ST_SEQ : ST_IDLE;
                end
            endcase
        end
        res_next.seq_number = link_seq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_index_reg <= '0;
            remaining_reg  <= '0;
            crc_reg        <= '0;
            link_seq_reg   <= '0;
        end
        else if (s1_fire)
        begin
            state_reg      <= state_next;
            byte_index_reg <= byte_index_next;
            remaining_reg  <= remaining_next;
            crc_reg        <= crc_next;
            link_seq_reg   <= link_seq_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign msg_valid    = res_reg.msg_valid;
    assign msg_byte     = res_reg.msg_byte;
    assign msg_index    = res_reg.msg_index;
    assign frame_ok     = res_reg.frame_ok;
    assign frame_length = res_reg.frame_length;
    assign frame_error  = res_reg.frame_error;
    assign seq_number   = res_reg.seq_number;

endmodule
